// ----- design/ptfd_pkg.sv -----
`default_nettype none

package ptfd_pkg;

    // Parameter defaults
    localparam int SAMPLE_BITS_DEF    = 10;
    localparam int RUN_COUNT_BITS_DEF = 16;

    // Fixed field widths
    localparam int THRESH_W   = 10;
    localparam int GAIN_W     = 8;
    localparam int DRIVE_W    = 9;
    localparam int ERR_W      = 4;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    // Derivative numerator: gain (8 bit) times |error change| (at most 10, 4 bit)
    localparam int DMAG_W = 4;
    localparam int NUM_W  = GAIN_W + DMAG_W;
    localparam int CNT_W  = $clog2(NUM_W);
    // Signed working width for the drive sums
    localparam int CALC_W = 16;
    localparam int PE_W   = 12;

    localparam int DRIVE_LIMIT = 255;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_SPEED = 8'd3;

    // Register reset values
    localparam logic [THRESH_W-1:0] THRESHOLD_RST  = 10'd100;
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 8'd40;
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST = 8'd70;
    localparam logic [GAIN_W-1:0]   BASE_SPEED_RST = 8'd100;

    // Line error codes
    localparam logic signed [ERR_W-1:0] ERR_CENTRE   = 4'sd0;
    localparam logic signed [ERR_W-1:0] ERR_LEFT     = -4'sd1;
    localparam logic signed [ERR_W-1:0] ERR_RIGHT    = 4'sd1;
    localparam logic signed [ERR_W-1:0] ERR_LOST_POS = 4'sd5;
    localparam logic signed [ERR_W-1:0] ERR_LOST_NEG = -4'sd5;

    // Microcode
    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] upc_t;

    localparam upc_t PC_WAIT     = 3'd0;
    localparam upc_t PC_CLASSIFY = 3'd1;
    localparam upc_t PC_SETUP    = 3'd2;
    localparam upc_t PC_DIVIDE   = 3'd3;
    localparam upc_t PC_SLOT     = 3'd4;
    localparam upc_t PC_FINISH   = 3'd5;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_NO_INPUT,
        JC_DIV_MORE,
        JC_OUT_FULL
    } jump_cond_t;

    typedef struct packed {
        logic       accept;
        logic       classify;
        logic       setup;
        logic       div_step;
        logic       finish;
        jump_cond_t cond;
        upc_t       target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic div_more;
        logic out_full;
    } seq_status_t;

    localparam ucode_t UC_NOP = '{accept: 1'b0, classify: 1'b0, setup: 1'b0,
                                  div_step: 1'b0, finish: 1'b0,
                                  cond: JC_ALWAYS, target: PC_WAIT};

    function automatic ucode_t ucode_rom(input upc_t pc);
        ucode_t uc;
        uc = UC_NOP;
        unique case (pc)
            PC_WAIT:
            begin
                uc.accept = 1'b1;
                uc.cond   = JC_NO_INPUT;
                uc.target = PC_WAIT;
            end
            PC_CLASSIFY:
            begin
                uc.classify = 1'b1;
                uc.cond     = JC_NEXT;
            end
            PC_SETUP:
            begin
                uc.setup = 1'b1;
                uc.cond  = JC_NEXT;
            end
            PC_DIVIDE:
            begin
                uc.div_step = 1'b1;
                uc.cond     = JC_DIV_MORE;
                uc.target   = PC_DIVIDE;
            end
            PC_SLOT:
            begin
                uc.cond   = JC_OUT_FULL;
                uc.target = PC_SLOT;
            end
            PC_FINISH:
            begin
                uc.finish = 1'b1;
                uc.cond   = JC_ALWAYS;
                uc.target = PC_WAIT;
            end
            default:
            begin
                uc = UC_NOP;
            end
        endcase
        return uc;
    endfunction

endpackage

`default_nettype wire

// ----- design/ptfd_if.sv -----
`default_nettype none

interface ptfd_sense_if #(
    parameter int SAMPLE_BITS = ptfd_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [SAMPLE_BITS-1:0] left_sample;
    logic [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, action, left_sample, right_sample, input ready);
    modport sink   (input valid, action, left_sample, right_sample, output ready);
endinterface

interface ptfd_drive_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ptfd_pkg::DRIVE_W-1:0]   first_motor_drive;
    logic signed [ptfd_pkg::DRIVE_W-1:0]   second_motor_drive;
    logic signed [ptfd_pkg::ERR_W-1:0]     line_error;

    modport source (output valid, first_motor_drive, second_motor_drive, line_error,
                    input ready);
    modport sink   (input valid, first_motor_drive, second_motor_drive, line_error,
                    output ready);
endinterface

interface ptfd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ptfd_pkg::CFG_ADDR_W-1:0]    index;
    logic [ptfd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/ptfd_seq.sv -----
`default_nettype none

// Microcode sequencer: step counter, control store, conditional jump.
module ptfd_seq (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ptfd_pkg::seq_status_t status,
    output ptfd_pkg::ucode_t           ctrl
);

    ptfd_pkg::upc_t pc_reg;
    ptfd_pkg::upc_t pc_next;
    logic           take;

    assign ctrl = ptfd_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            ptfd_pkg::JC_NEXT:     take = 1'b0;
            ptfd_pkg::JC_ALWAYS:   take = 1'b1;
            ptfd_pkg::JC_NO_INPUT: take = !status.in_valid;
            ptfd_pkg::JC_DIV_MORE: take = status.div_more;
            ptfd_pkg::JC_OUT_FULL: take = status.out_full;
            default:               take = 1'b1;
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            pc_next = ctrl.target;
        end
        else
        begin
            pc_next = pc_reg + ptfd_pkg::upc_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ptfd_pkg::PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/pd_tape_follow_drive.sv -----
// Sequence after an input transfer: classify, setup, 12 divider steps,
//   slot check, finish, then back to wait for the next item.
// No new item is accepted until the current one is finished; the 12-step
//   restoring divider forms the derivative term; a stalled result holds the sequencer.
// Reset (rst_n, async, active low): registers to their defaults, error
//   history and run counters cleared, output empty. Config writes always taken.
`default_nettype none

module pd_tape_follow_drive #(
    parameter int SAMPLE_BITS    = ptfd_pkg::SAMPLE_BITS_DEF,
    parameter int RUN_COUNT_BITS = ptfd_pkg::RUN_COUNT_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ptfd_sense_if.sink  sense,
    ptfd_drive_if.source drive,
    ptfd_cfg_if.sink    cfg
);

    localparam int CMP_W = (SAMPLE_BITS > ptfd_pkg::THRESH_W) ?
                           SAMPLE_BITS : ptfd_pkg::THRESH_W;
    // Step count is prev + current run, formed one bit wider so it never wraps
    localparam int STEP_W = RUN_COUNT_BITS + 1;

    localparam int ERR_W  = ptfd_pkg::ERR_W;
    localparam int CALC_W = ptfd_pkg::CALC_W;
    localparam int NUM_W  = ptfd_pkg::NUM_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ptfd_pkg::THRESH_W-1:0] thresh_reg;
    logic [ptfd_pkg::GAIN_W-1:0]   pgain_reg;
    logic [ptfd_pkg::GAIN_W-1:0]   dgain_reg;
    logic [ptfd_pkg::GAIN_W-1:0]   base_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= ptfd_pkg::THRESHOLD_RST;
            pgain_reg  <= ptfd_pkg::PROP_GAIN_RST;
            dgain_reg  <= ptfd_pkg::DERIV_GAIN_RST;
            base_reg   <= ptfd_pkg::BASE_SPEED_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ptfd_pkg::REG_THRESHOLD:  thresh_reg <= cfg.data[ptfd_pkg::THRESH_W-1:0];
                ptfd_pkg::REG_PROP_GAIN:  pgain_reg  <= cfg.data[ptfd_pkg::GAIN_W-1:0];
                ptfd_pkg::REG_DERIV_GAIN: dgain_reg  <= cfg.data[ptfd_pkg::GAIN_W-1:0];
                ptfd_pkg::REG_BASE_SPEED: base_reg   <= cfg.data[ptfd_pkg::GAIN_W-1:0];
                default:                  ; // unknown index: dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    ptfd_pkg::ucode_t      ctrl;
    ptfd_pkg::seq_status_t status;

    logic [ptfd_pkg::CNT_W-1:0] cnt_reg;
    logic                       out_valid_reg;

    assign status.in_valid = sense.valid;
    assign status.div_more = (cnt_reg != '0);
    assign status.out_full = out_valid_reg && !drive.ready;

    ptfd_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign sense.ready = ctrl.accept;

    // ------------------------------------------------------------------
    // Input capture
    // ------------------------------------------------------------------
    logic                   act_reg;
    logic [SAMPLE_BITS-1:0] left_reg;
    logic [SAMPLE_BITS-1:0] right_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.accept && sense.valid)
        begin
            act_reg   <= sense.action;
            left_reg  <= sense.left_sample;
            right_reg <= sense.right_sample;
        end
    end

    // ------------------------------------------------------------------
    // Classify: line error and run bookkeeping
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0]    prior_err_reg;
    logic signed [ERR_W-1:0]    ebc_reg;       // error before last change
    logic [RUN_COUNT_BITS-1:0]  prev_run_reg;
    logic [RUN_COUNT_BITS-1:0]  cur_run_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [ERR_W-1:0]    err_new;
    logic                       left_seen;
    logic                       right_seen;

    assign left_seen  = CMP_W'(left_reg)  > CMP_W'(thresh_reg);
    assign right_seen = CMP_W'(right_reg) > CMP_W'(thresh_reg);

    always_comb
    begin
        priority if (left_seen && right_seen)
        begin
            err_new = ptfd_pkg::ERR_CENTRE;
        end
        else if (left_seen)
        begin
            err_new = ptfd_pkg::ERR_LEFT;
        end
        else if (right_seen)
        begin
            err_new = ptfd_pkg::ERR_RIGHT;
        end
        else if (prior_err_reg > ptfd_pkg::ERR_CENTRE)
        begin
            err_new = ptfd_pkg::ERR_LOST_POS;   // off the tape, last seen right
        end
        else
        begin
            err_new = ptfd_pkg::ERR_LOST_NEG;
        end
    end

    // ------------------------------------------------------------------
    // Setup: step count, proportional product, derivative numerator
    // ------------------------------------------------------------------
    logic signed [ERR_W:0]            d_err;
    logic [ptfd_pkg::DMAG_W-1:0]      d_mag;
    logic signed [ptfd_pkg::GAIN_W+ERR_W:0] pe_full;

    logic [STEP_W-1:0]                steps_reg;
    logic signed [ptfd_pkg::PE_W-1:0] pe_reg;
    logic                             r_neg_reg;
    logic [NUM_W-1:0]                 num_reg;   // dividend, becomes quotient
    logic [STEP_W-1:0]                rem_reg;

    assign d_err   = {err_reg[ERR_W-1], err_reg} - {ebc_reg[ERR_W-1], ebc_reg};
    assign d_mag   = d_err[ERR_W] ? ptfd_pkg::DMAG_W'(-d_err) : ptfd_pkg::DMAG_W'(d_err);
    assign pe_full = $signed({1'b0, pgain_reg}) * err_reg;

    // Restoring divider step
    logic [STEP_W:0] rem_shift;
    logic [STEP_W:0] rem_diff;
    logic            q_bit;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, steps_reg};
    assign q_bit     = (rem_shift >= {1'b0, steps_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_err_reg <= ptfd_pkg::ERR_CENTRE;
            ebc_reg       <= ptfd_pkg::ERR_CENTRE;
            prev_run_reg  <= '0;
            cur_run_reg   <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (ctrl.classify)
            begin
                prior_err_reg <= err_new;
                if (err_new != prior_err_reg)
                begin
                    ebc_reg      <= prior_err_reg;
                    prev_run_reg <= cur_run_reg;
                    cur_run_reg  <= RUN_COUNT_BITS'(1);
                end
            end
            if (ctrl.setup)
            begin
                cur_run_reg <= cur_run_reg + RUN_COUNT_BITS'(1);   // wraps
                cnt_reg     <= ptfd_pkg::CNT_W'(NUM_W - 1);
            end
            else if (ctrl.div_step && (cnt_reg != '0))
            begin
                cnt_reg <= cnt_reg - ptfd_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.classify)
        begin
            err_reg <= err_new;
        end
        if (ctrl.setup)
        begin
            steps_reg <= {1'b0, prev_run_reg} + {1'b0, cur_run_reg};
            pe_reg    <= pe_full[ptfd_pkg::PE_W-1:0];
            r_neg_reg <= d_err[ERR_W];
            num_reg   <= dgain_reg * d_mag;
            rem_reg   <= '0;
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= q_bit ? rem_diff[STEP_W-1:0] : rem_shift[STEP_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], q_bit};
        end
    end

    // ------------------------------------------------------------------
    // Finish: drive = trunc(base +- pe +- r/steps), signs flipped in reverse
    // ------------------------------------------------------------------
    // floor(r/s) from |r| = q*s + rem: q when r >= 0, -(q + [rem != 0]) else.
    // A fractional part lifts a negative floor by one to truncate toward zero.
    function automatic logic signed [ptfd_pkg::DRIVE_W-1:0] settle(
        input logic signed [ptfd_pkg::CALC_W-1:0] v,
        input logic                               frac,
        input logic                               rev
    );
        logic signed [ptfd_pkg::CALC_W-1:0] t;
        logic signed [ptfd_pkg::CALC_W-1:0] lim;
        t   = (frac && (v < 0)) ? v + ptfd_pkg::CALC_W'(1) : v;
        t   = rev ? -t : t;
        lim = ptfd_pkg::CALC_W'(ptfd_pkg::DRIVE_LIMIT);
        if (t > lim)
        begin
            t = lim;
        end
        else if (t < -lim)
        begin
            t = -lim;
        end
        return t[ptfd_pkg::DRIVE_W-1:0];
    endfunction

    logic                      zero_steps;
    logic                      frac;
    logic signed [CALC_W-1:0]  q_w;
    logic signed [CALC_W-1:0]  q_up;
    logic signed [CALC_W-1:0]  base_w;
    logic signed [CALC_W-1:0]  pe_w;
    logic signed [CALC_W-1:0]  fl_first;
    logic signed [CALC_W-1:0]  fl_second;
    logic signed [CALC_W-1:0]  v_first;
    logic signed [CALC_W-1:0]  v_second;

    // No steps yet: derivative term dropped
    assign zero_steps = (steps_reg == '0);
    assign frac       = !zero_steps && (rem_reg != '0);
    assign q_w        = zero_steps ? '0 : $signed(CALC_W'(num_reg));
    assign q_up       = q_w + $signed(CALC_W'(frac));
    assign base_w     = $signed(CALC_W'(base_reg));
    assign pe_w       = CALC_W'(pe_reg);
    assign fl_first   = r_neg_reg ? -q_up : q_w;    // floor(+r/s)
    assign fl_second  = r_neg_reg ? q_w : -q_up;    // floor(-r/s)
    assign v_first    = base_w + pe_w + fl_first;
    assign v_second   = base_w - pe_w + fl_second;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [ptfd_pkg::DRIVE_W-1:0] drv1_reg;
    logic signed [ptfd_pkg::DRIVE_W-1:0] drv2_reg;
    logic signed [ERR_W-1:0]             out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (drive.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            drv1_reg    <= settle(v_first, frac, act_reg);
            drv2_reg    <= settle(v_second, frac, act_reg);
            out_err_reg <= err_reg;
        end
    end

    assign drive.valid              = out_valid_reg;
    assign drive.first_motor_drive  = drv1_reg;
    assign drive.second_motor_drive = drv2_reg;
    assign drive.line_error         = out_err_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Accepted item goes straight to classification
    a_accept_to_classify: assert property (@(posedge clk) disable iff (!rst_n)
        (sense.valid && sense.ready) |=> ctrl.classify)
        else $error("input transfer not followed by classify step");

    // Finish never overwrites a result still waiting
    a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |-> !out_valid_reg)
        else $error("result overwritten before transfer");

    // Offered error is one of the five legal codes
    a_error_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_err_reg == ptfd_pkg::ERR_CENTRE
                        || out_err_reg == ptfd_pkg::ERR_LEFT
                        || out_err_reg == ptfd_pkg::ERR_RIGHT
                        || out_err_reg == ptfd_pkg::ERR_LOST_POS
                        || out_err_reg == ptfd_pkg::ERR_LOST_NEG))
        else $error("illegal line error");

    // Saturation keeps drives off the one code beyond -255
    a_drive_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drv1_reg != {1'b1, {(ptfd_pkg::DRIVE_W-1){1'b0}}}
                        && drv2_reg != {1'b1, {(ptfd_pkg::DRIVE_W-1){1'b0}}}))
        else $error("drive outside saturation range");

endmodule

`default_nettype wire

// ----- tb/pd_tape_follow_drive_test.sv -----
`default_nettype none

module pd_tape_follow_drive_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptfd_pkg::*;

    localparam int SB         = SAMPLE_BITS_DEF;
    localparam int RB         = RUN_COUNT_BITS_DEF;
    localparam int SAMPLE_MAX = (1 << SB) - 1;

    // Register indexes outside the map; writes to them must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LOW = 8'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_TOP = 8'hFF;

    localparam int STEADY_TICKS  = 40;             // one unbroken run with no idling
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_TICKS   = 260;
    localparam int HOLD_CYCLES   = 250;            // long result-side stall
    localparam int DRAIN_CYCLES  = 40;             // outlasts the block's latency, catches stray results
    localparam int TIME_LIMIT_NS = 1_000_000;

    typedef enum logic [1:0] {
        TAPE_BOTH,
        TAPE_LEFT,
        TAPE_RIGHT,
        TAPE_NONE
    } tape_view_t;

    typedef struct packed {
        logic          action;
        logic [SB-1:0] left_sample;
        logic [SB-1:0] right_sample;
    } tick_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] first_drive;
        logic signed [DRIVE_W-1:0] second_drive;
        logic signed [ERR_W-1:0]   line_err;
    } drive_t;

    logic clk = 1'b0;
    logic rst_n;

    ptfd_sense_if #(.SAMPLE_BITS(SB)) sense_bus ();
    ptfd_drive_if                     drive_bus ();
    ptfd_cfg_if                       cfg_bus ();

    pd_tape_follow_drive #(
        .SAMPLE_BITS    (SB),
        .RUN_COUNT_BITS (RB)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sense (sense_bus),
        .drive (drive_bus),
        .cfg   (cfg_bus)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the register file and of the steering history
    // ------------------------------------------------------------------
    logic [THRESH_W-1:0]     thr_cfg  = THRESHOLD_RST;
    logic [GAIN_W-1:0]       kp_cfg   = PROP_GAIN_RST;
    logic [GAIN_W-1:0]       kd_cfg   = DERIV_GAIN_RST;
    logic [GAIN_W-1:0]       base_cfg = BASE_SPEED_RST;

    logic signed [ERR_W-1:0] last_err      = ERR_CENTRE;
    logic signed [ERR_W-1:0] err_at_change = ERR_CENTRE;
    logic [RB-1:0]           earlier_run   = '0;
    logic [RB-1:0]           this_run      = '0;

    tick_t  tick_q[$];          // ticks waiting for the sense driver
    drive_t drive_expect_q[$];  // predicted drive results, oldest first

    int queued_ticks    = 0;
    int checked_results = 0;
    int fail_count      = 0;
    int hold_left       = 0;
    bit steady          = 1'b0;  // no idling on either side while set
    bit stall_req       = 1'b0;  // asks the result side for one long hold-off

    function automatic logic signed [DRIVE_W-1:0] saturate_drive(input longint v);
        if (v > DRIVE_LIMIT)
            return DRIVE_W'(DRIVE_LIMIT);
        if (v < -DRIVE_LIMIT)
            return DRIVE_W'(-DRIVE_LIMIT);
        return DRIVE_W'(v);
    endfunction

    // Steering law for one sensor tick; advances the error history and run counters.
    function automatic drive_t predict_drive(input tick_t t);
        drive_t                  d;
        logic signed [ERR_W-1:0] err;
        logic [RB:0]             span;
        longint                  steps, corr, base_num, e, eb, m1, m2;
        bit                      lseen, rseen;
        lseen = t.left_sample > thr_cfg;
        rseen = t.right_sample > thr_cfg;
        if (lseen)
            err = rseen ? ERR_CENTRE : ERR_LEFT;
        else if (rseen)
            err = ERR_RIGHT;
        else
            err = (last_err > ERR_CENTRE) ? ERR_LOST_POS : ERR_LOST_NEG;
        // a new error value closes the current run
        if (err != last_err)
        begin
            err_at_change = last_err;
            earlier_run   = this_run;
            this_run      = RB'(1);
        end
        span = earlier_run + this_run;  // one bit wider, no wrap
        e    = err;
        eb   = err_at_change;
        if (span == 0)
        begin
            // empty step count: proportional term only
            steps = 1;
            corr  = longint'(kp_cfg) * e;
        end
        else
        begin
            steps = span;
            corr  = longint'(kp_cfg) * e * steps + longint'(kd_cfg) * (e - eb);
        end
        base_num = longint'(base_cfg) * steps;
        if (t.action)
        begin
            m1 = (-base_num - corr) / steps;
            m2 = (-base_num + corr) / steps;
        end
        else
        begin
            m1 = (base_num + corr) / steps;
            m2 = (base_num - corr) / steps;
        end
        this_run = this_run + 1'b1;
        last_err = err;
        d.first_drive  = saturate_drive(m1);
        d.second_drive = saturate_drive(m2);
        d.line_err     = err;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_raw(input int act, input int l, input int r);
        tick_t t;
        t.action       = act[0];
        t.left_sample  = SB'(l);
        t.right_sample = SB'(r);
        tick_q.push_back(t);
        queued_ticks++;
    endfunction

    // Sample on the requested side of the threshold, weighted to the edges
    function automatic int pick_sample(input bit seen);
        int thr;
        thr = thr_cfg;
        if (seen)
        begin
            if (thr >= SAMPLE_MAX)
                return $urandom_range(SAMPLE_MAX);  // tape cannot be seen at all
            case ($urandom_range(9))
                0:       return thr + 1;
                1:       return SAMPLE_MAX;
                default: return $urandom_range(SAMPLE_MAX, thr + 1);
            endcase
        end
        case ($urandom_range(9))
            0:       return thr;
            1:       return 0;
            default: return $urandom_range(thr, 0);
        endcase
    endfunction

    function automatic void push_tick(input int act, input tape_view_t view);
        push_raw(act, pick_sample(view == TAPE_BOTH || view == TAPE_LEFT),
                 pick_sample(view == TAPE_BOTH || view == TAPE_RIGHT));
    endfunction

    // Blocks until every queued tick has produced its checked result
    task automatic settle();
        while (checked_results != queued_ticks)
            @(posedge clk);
    endtask

    // Register write; only called with nothing in flight, so the shadow
    // copy can be updated at the transfer edge
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            REG_THRESHOLD:  thr_cfg  = val[THRESH_W-1:0];
            REG_PROP_GAIN:  kp_cfg   = val[GAIN_W-1:0];
            REG_DERIV_GAIN: kd_cfg   = val[GAIN_W-1:0];
            REG_BASE_SPEED: base_cfg = val[GAIN_W-1:0];
            default:        ;
        endcase
        cfg_bus.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sense driver: predicts on each input transfer, then offers the next
    // tick from the queue unless it idles this cycle
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tick_t taken;
        tick_t next_tick;
        if (sense_bus.valid && sense_bus.ready)
        begin
            taken.action       = sense_bus.action;
            taken.left_sample  = sense_bus.left_sample;
            taken.right_sample = sense_bus.right_sample;
            drive_expect_q.push_back(predict_drive(taken));
        end
        if (!sense_bus.valid || sense_bus.ready)
        begin
            if (tick_q.size() != 0 && (steady || $urandom_range(99) >= 7))
            begin
                next_tick = tick_q.pop_front();
                sense_bus.valid        <= 1'b1;
                sense_bus.action       <= next_tick.action;
                sense_bus.left_sample  <= next_tick.left_sample;
                sense_bus.right_sample <= next_tick.right_sample;
            end
            else
                sense_bus.valid <= 1'b0;
        end
    end

    // Result-side ready: random idling, plus one long hold-off on request
    // so the block backs up and stalls its sense input
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            drive_bus.ready <= 1'b0;
        end
        else if (stall_req)
        begin
            stall_req       <= 1'b0;
            hold_left       <= HOLD_CYCLES;
            drive_bus.ready <= 1'b0;
        end
        else
            drive_bus.ready <= steady || ($urandom_range(99) >= 7);
    end

    // Result monitor: each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        drive_t want;
        if (drive_bus.valid && drive_bus.ready)
        begin
            if (drive_expect_q.size() == 0)
            begin
                $error("drive result transfer with no prediction pending");
                fail_count++;
            end
            else
            begin
                want = drive_expect_q.pop_front();
                if (drive_bus.first_motor_drive !== want.first_drive)
                begin
                    $error("first_motor_drive: expected %0d, got %0d",
                           want.first_drive, drive_bus.first_motor_drive);
                    fail_count++;
                end
                if (drive_bus.second_motor_drive !== want.second_drive)
                begin
                    $error("second_motor_drive: expected %0d, got %0d",
                           want.second_drive, drive_bus.second_motor_drive);
                    fail_count++;
                end
                if (drive_bus.line_error !== want.line_err)
                begin
                    $error("line_error: expected %0d, got %0d",
                           want.line_err, drive_bus.line_error);
                    fail_count++;
                end
                checked_results++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int         p;
        int         n;
        int         run;
        tape_view_t view;
        sense_bus.valid        = 1'b0;
        sense_bus.action       = 1'b0;
        sense_bus.left_sample  = '0;
        sense_bus.right_sample = '0;
        drive_bus.ready        = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = '0;
        cfg_bus.data           = '0;
        rst_n                  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings. First tick matches the cleared history, so the
        // step count is still zero and the derivative must drop out.
        push_raw(1'b0, SAMPLE_MAX, SAMPLE_MAX);
        push_raw(1'b1, 101, 101);          // just over threshold
        push_raw(1'b0, 101, 100);          // level equal to threshold is not tape
        push_raw(1'b1, 0, SAMPLE_MAX);     // right only, reverse
        push_raw(1'b0, 0, 0);              // lost after positive error: +5
        push_raw(1'b1, 100, 100);
        push_raw(1'b0, SAMPLE_MAX, 0);     // left only
        push_raw(1'b0, 50, 7);             // lost after negative error: -5
        push_raw(1'b1, 0, 0);
        push_raw(1'b0, 512, 512);
        settle();

        // Full gains and speed: large drives that exercise saturation
        write_reg(REG_PROP_GAIN, 16'hFFFF);
        write_reg(REG_DERIV_GAIN, 16'h00FF);
        write_reg(REG_BASE_SPEED, 16'hFFFF);
        push_raw(1'b0, SAMPLE_MAX, 0);
        push_raw(1'b1, 0, SAMPLE_MAX);
        push_raw(1'b0, 0, 0);
        push_raw(1'b1, 0, 0);
        push_raw(1'b1, SAMPLE_MAX, SAMPLE_MAX);
        settle();

        // Zero speed; writes beyond the register map must change nothing
        write_reg(REG_BASE_SPEED, 16'h0000);
        write_reg(REG_UNUSED_LOW, 16'hFFFF);
        write_reg(REG_UNUSED_TOP, 16'hFFFF);
        push_raw(1'b1, 0, 700);
        push_raw(1'b0, 700, 0);
        push_raw(1'b0, 3, 3);
        settle();

        // Highest threshold: no level can exceed it, always lost
        write_reg(REG_THRESHOLD, 16'hFFFF);
        push_raw(1'b0, SAMPLE_MAX, SAMPLE_MAX);
        push_raw(1'b1, SAMPLE_MAX, 0);
        settle();

        // Zero threshold and zero gains
        write_reg(REG_THRESHOLD, 16'h0000);
        write_reg(REG_PROP_GAIN, 16'h0000);
        write_reg(REG_DERIV_GAIN, 16'h0000);
        push_raw(1'b0, 1, 0);
        push_raw(1'b1, 0, 0);
        push_raw(1'b0, 0, 1);
        push_raw(1'b1, 1, 1);
        settle();

        // One unbroken right-only run with no idling on either side
        write_reg(REG_THRESHOLD, 16'd512);
        write_reg(REG_PROP_GAIN, 16'd25);
        write_reg(REG_DERIV_GAIN, 16'd255);
        write_reg(REG_BASE_SPEED, 16'd128);
        steady = 1'b1;
        for (n = 0; n < STEADY_TICKS; n++)
            push_tick($urandom_range(1), TAPE_RIGHT);
        settle();
        steady = 1'b0;

        // Random phases, one setting each; first all zero, second full gains and speed, high threshold
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(REG_THRESHOLD, 16'd0);
                    write_reg(REG_PROP_GAIN, 16'd0);
                    write_reg(REG_DERIV_GAIN, 16'd0);
                    write_reg(REG_BASE_SPEED, 16'd0);
                end
                1:
                begin
                    write_reg(REG_THRESHOLD, 16'd1000);
                    write_reg(REG_PROP_GAIN, 16'd255);
                    write_reg(REG_DERIV_GAIN, 16'd255);
                    write_reg(REG_BASE_SPEED, 16'd255);
                end
                default:
                begin
                    write_reg(REG_THRESHOLD, 16'($urandom_range(16'hFFFF)));
                    write_reg(REG_PROP_GAIN, 16'($urandom_range(16'hFFFF)));
                    write_reg(REG_DERIV_GAIN, 16'($urandom_range(16'hFFFF)));
                    write_reg(REG_BASE_SPEED, 16'($urandom_range(16'hFFFF)));
                end
            endcase
            n = 0;
            while (n < PHASE_TICKS)
            begin
                if ($urandom_range(99) < 15)
                begin
                    // noise: any levels at all
                    push_raw($urandom_range(1), $urandom_range(SAMPLE_MAX),
                             $urandom_range(SAMPLE_MAX));
                    n++;
                end
                else
                begin
                    // a run of one tape view, mostly short, now and then long
                    view = tape_view_t'($urandom_range(3));
                    run  = ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                                    : $urandom_range(12, 1);
                    repeat (run) push_tick($urandom_range(1), view);
                    n += run;
                end
            end
            // long result hold-off while the sender still has a full queue
            if (p == 2)
                stall_req = 1'b1;
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIME_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
